// ===== rtl/alids_pkg.sv =====
// Shared types and constants for the array list insert/delete/search core.
`default_nettype none
package alids_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int QUEUE_DEPTH      = 2;

  localparam int OPCODE_W = 3;
  localparam int POS_W    = 5;
  localparam int KEY_W    = 64;
  localparam int DATA_W   = 64;
  localparam int MIDX_W   = 4;
  localparam int CNT_W    = 5;

  localparam int S_TDATA_W = 136;
  localparam int M_TDATA_W = 16;

  localparam logic [OPCODE_W-1:0] OP_INS_FIRST = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INS_LAST  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_INS_POS   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DEL_FIRST = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DEL_LAST  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_DEL_POS   = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_DEL_KEY   = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_FIND      = 3'd7;

  typedef enum logic [1:0] {
    K_INS,
    K_DEL,
    K_DEL_KEY,
    K_FIND
  } kind_t;

  typedef enum logic [1:0] {
    SEL_FRONT,
    SEL_BACK,
    SEL_POS,
    SEL_MATCH
  } sel_t;

  typedef struct packed {
    kind_t              kind;
    sel_t               sel;
    logic [POS_W-1:0]   position;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
  } cmd_t;

  // declared high to low so applied sits in bit 0
  typedef struct packed {
    logic              is_empty;
    logic              is_full;
    logic [CNT_W-1:0]  item_count;
    logic [MIDX_W-1:0] match_index;
    logic              found;
    logic              applied;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/array_list_insert_delete_search_core.sv =====
// Top level of the array list core: ordered record list with shift insert/delete and key search.
//
// Requests enter on the s_ channel, one word per request: s_tuser carries the opcode
// (insert front/back/position, delete front/back/position, delete by key, find),
// s_tdata the position, the 64-bit key and the 64-bit data. Every request returns
// exactly one status word on the m_ channel, in request order.
// The front end decodes requests into a two-entry command queue; the list engine
// pops one command at a time and runs it through its sequencer.
// With the engine idle, an accepted request is written into the queue, loaded by the
// engine and run in its execute step, which raises m_tvalid; delete by key and find
// also pass through the register compare and encode steps before execute.
// The engine takes the next command only after the execute step of the current one;
// its sequencer steps are load, compare, encode and execute, the middle two for key operations.
// The status word sits in an output register; while m_tready is low the engine
// holds the next finished command in its execute step and the queue keeps
// accepting until it fills, then s_tready drops.
// Reset (rst, synchronous) empties the list and the queue; record contents are not
// cleared and are never read beyond the current count.
`default_nettype none
module array_list_insert_delete_search_core
  import alids_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // position[4:0], entry_key[68:5], entry_data[132:69], zero fill
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // opcode[2:0]
  input  wire logic [OPCODE_W-1:0]  s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // applied[0], found[1], match_index[5:2], item_count[10:6], is_full[11],
  // is_empty[12], zero fill
  output logic [M_TDATA_W-1:0]      m_tdata
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  alids_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  alids_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_cmd    (push_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  alids_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

// ===== rtl/alids_front.sv =====
// Front end: accepts request words and decodes them into list commands.
`default_nettype none
module alids_front
  import alids_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  input  wire logic [OPCODE_W-1:0]  s_tuser,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output cmd_t                      push_cmd
);

  kind_t kind;
  sel_t  sel;

  always_comb begin
    kind = K_FIND;
    sel  = SEL_MATCH;
    case (s_tuser)
      OP_INS_FIRST: begin kind = K_INS;     sel = SEL_FRONT; end
      OP_INS_LAST:  begin kind = K_INS;     sel = SEL_BACK;  end
      OP_INS_POS:   begin kind = K_INS;     sel = SEL_POS;   end
      OP_DEL_FIRST: begin kind = K_DEL;     sel = SEL_FRONT; end
      OP_DEL_LAST:  begin kind = K_DEL;     sel = SEL_BACK;  end
      OP_DEL_POS:   begin kind = K_DEL;     sel = SEL_POS;   end
      OP_DEL_KEY:   begin kind = K_DEL_KEY; sel = SEL_MATCH; end
      OP_FIND:      begin kind = K_FIND;    sel = SEL_MATCH; end
      default:      begin kind = K_FIND;    sel = SEL_MATCH; end
    endcase
  end

  assign s_tready          = push_ready;
  assign push_valid        = s_tvalid;
  assign push_cmd.kind     = kind;
  assign push_cmd.sel      = sel;
  assign push_cmd.position = s_tdata[POS_W-1:0];
  assign push_cmd.key      = s_tdata[POS_W +: KEY_W];
  assign push_cmd.data     = s_tdata[POS_W+KEY_W +: DATA_W];

  // a decoded request never selects the match slot unless it searches
  assert property (@(posedge clk) disable iff (rst)
    push_valid && (push_cmd.kind == K_INS || push_cmd.kind == K_DEL)
      |-> push_cmd.sel != SEL_MATCH)
    else $error("positional command decoded with match select");

endmodule
`default_nettype wire

// ===== rtl/alids_queue.sv =====
// Short command queue between the front end and the list engine.
`default_nettype none
module alids_queue
  import alids_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire cmd_t in_cmd,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      out_cmd
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [FW-1:0] fill;
  logic          push;
  logic          pop;

  assign in_ready  = fill != FW'(QUEUE_DEPTH);
  assign out_valid = fill != '0;
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + FW'(1);
      end else if (pop && !push) begin
        fill <= fill - FW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= FW'(QUEUE_DEPTH))
    else $error("queue overfilled");

  assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> fill == $past(fill) + FW'(1))
    else $error("queue fill missed a push");

  assert property (@(posedge clk) disable iff (rst)
    fill == '0 |-> rd_ptr == wr_ptr)
    else $error("queue pointers disagree when empty");

endmodule
`default_nettype wire

// ===== rtl/alids_back.sv =====
// List engine: record cells, key compare, shift insert/delete and result register.
`default_nettype none
module alids_back
  import alids_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  output logic                      q_ready,
  input  wire cmd_t                 q_cmd,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_ENC, ST_EXEC} state_t;

  state_t               state;
  logic [KEY_W-1:0]     key_store  [CAPACITY];
  logic [DATA_W-1:0]    data_store [CAPACITY];
  logic [CW-1:0]        count;
  cmd_t                 cmd;
  logic [CAPACITY-1:0]  match_vec;
  logic [CAPACITY-1:0]  match_now;
  logic [CAPACITY-1:0]  match_first;
  logic [AW-1:0]        match_enc;
  logic                 found;
  logic [AW-1:0]        match_idx;
  res_t                 result;

  logic [AW-1:0]        count_ext;
  logic [AW-1:0]        count_next;
  logic [AW-1:0]        at;
  logic                 ok;
  logic                 do_ins;
  logic                 do_del;
  logic                 out_free;
  logic                 exec_fire;

  assign count_ext = AW'(count);
  assign out_free  = !m_tvalid || m_tready;
  assign exec_fire = (state == ST_EXEC) && out_free;
  assign q_ready   = state == ST_IDLE;
  assign m_tdata   = M_TDATA_W'(result);

  always_comb begin
    match_now = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_now[i] = (key_store[i] == cmd.key) && (AW'(i) < count_ext);
    end
  end

  // isolate the lowest set bit, then encode it
  assign match_first = match_vec & (~match_vec + CAPACITY'(1));

  always_comb begin
    match_enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_first[i]) begin
        match_enc = match_enc | AW'(i);
      end
    end
  end

  always_comb begin
    at         = '0;
    ok         = 1'b0;
    count_next = count_ext;
    case (cmd.sel)
      SEL_FRONT: at = '0;
      SEL_BACK:  at = (cmd.kind == K_INS) ? count_ext : count_ext - AW'(1);
      SEL_POS:   at = AW'(cmd.position);
      SEL_MATCH: at = match_idx;
      default:   at = '0;
    endcase
    case (cmd.kind)
      K_INS: begin
        ok = (count_ext < AW'(CAPACITY)) && (at <= count_ext);
        if (ok) count_next = count_ext + AW'(1);
      end
      K_DEL: begin
        ok = (count_ext != '0) && (at < count_ext);
        if (ok) count_next = count_ext - AW'(1);
      end
      K_DEL_KEY: begin
        ok = found;
        if (ok) count_next = count_ext - AW'(1);
      end
      K_FIND:  ok = 1'b0;
      default: ok = 1'b0;
    endcase
  end

  assign do_ins = ok && (cmd.kind == K_INS);
  assign do_del = ok && (cmd.kind == K_DEL || cmd.kind == K_DEL_KEY);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [AW-1:0] IDX = AW'(i);
    logic [KEY_W-1:0]  up_key;
    logic [DATA_W-1:0] up_data;
    logic [KEY_W-1:0]  dn_key;
    logic [DATA_W-1:0] dn_data;

    if (i == 0) begin : g_head
      assign up_key  = cmd.key;
      assign up_data = cmd.data;
    end else begin : g_body
      assign up_key  = key_store[i-1];
      assign up_data = data_store[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign dn_key  = key_store[i];
      assign dn_data = data_store[i];
    end else begin : g_mid
      assign dn_key  = key_store[i+1];
      assign dn_data = data_store[i+1];
    end

    always_ff @(posedge clk) begin
      if (exec_fire && do_ins && IDX >= at) begin
        key_store[i]  <= (IDX == at) ? cmd.key  : up_key;
        data_store[i] <= (IDX == at) ? cmd.data : up_data;
      end else if (exec_fire && do_del && IDX >= at) begin
        key_store[i]  <= dn_key;
        data_store[i] <= dn_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (exec_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cmd       <= q_cmd;
            found     <= 1'b0;
            match_idx <= '0;
            state     <= (q_cmd.kind == K_DEL_KEY || q_cmd.kind == K_FIND) ? ST_CMP : ST_EXEC;
          end
        end
        ST_CMP: begin
          match_vec <= match_now;
          state     <= ST_ENC;
        end
        ST_ENC: begin
          found     <= |match_vec;
          match_idx <= match_enc;
          state     <= ST_EXEC;
        end
        ST_EXEC: begin
          if (out_free) begin
            result.applied     <= ok;
            result.found       <= found;
            result.match_index <= match_idx[MIDX_W-1:0];
            result.item_count  <= count_next[CNT_W-1:0];
            result.is_full     <= count_next >= AW'(CAPACITY);
            result.is_empty    <= count_next == '0;
            count              <= count_next[CW-1:0];
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count_ext <= AW'(CAPACITY))
    else $error("list count beyond capacity");

  assert property (@(posedge clk) disable iff (rst) state == ST_CMP |=> state == ST_ENC)
    else $error("compare not followed by encode");

  assert property (@(posedge clk) disable iff (rst)
    exec_fire && cmd.kind == K_FIND |=> $stable(count) && !result.applied)
    else $error("find changed the list");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC && found |-> match_idx < count_ext)
    else $error("match index outside the list");

endmodule
`default_nettype wire
